// ===== design/chxy_pkg.sv =====
// ----------------------------------------------------------------------------
// chxy_pkg: shared types and constants for the compass heading block
// Word formats, fixed-point widths and the CORDIC step angle table.
// ----------------------------------------------------------------------------
package chxy_pkg;

    localparam int SAMPLE_BITS  = 11;
    localparam int FRAC_BITS    = 24;
    localparam int GUARD_BITS   = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int HEAD_BITS    = 9;

    // Three headroom bits cover the CORDIC gain on the largest magnitude.
    localparam int XY_W = SAMPLE_BITS + GUARD_BITS + 3;
    // Angle accumulator: the running sum stays within about +/-100 degrees.
    localparam int Z_W  = FRAC_BITS + 9;
    // Clamped base angle, 0..90 degrees.
    localparam int TH_W = FRAC_BITS + 7;
    // Placed heading, 0..360 degrees.
    localparam int H_W  = FRAC_BITS + HEAD_BITS;

    typedef logic [SAMPLE_BITS-1:0]  t_sample;
    typedef logic signed [XY_W-1:0]  t_xy;
    typedef logic signed [Z_W-1:0]   t_angle;
    typedef logic [TH_W-1:0]         t_base;
    typedef logic [H_W-1:0]          t_head_q;
    typedef logic [HEAD_BITS-1:0]    t_heading;

    typedef struct packed {
        t_sample mag_x;
        t_sample mag_y;
    } t_in_word;

    typedef struct packed {
        t_heading heading_deg;
        logic     no_direction;
    } t_out_word;

    // State carried down the pipeline with each item.
    typedef struct packed {
        t_xy    x;
        t_xy    y;
        t_angle z;
        logic   fixed;
        logic   x_neg;
        logic   y_neg;
        logic   no_dir;
    } t_cordic;

    localparam t_angle   RIGHT_Q  = t_angle'(90) <<< FRAC_BITS;
    localparam t_angle   DIAG_Q   = t_angle'(45) <<< FRAC_BITS;
    localparam t_head_q  HALF_Q   = t_head_q'(180) << FRAC_BITS;
    localparam t_head_q  TURN_Q   = t_head_q'(360) << FRAC_BITS;
    localparam t_heading TURN_DEG = t_heading'(360);

    // atan(2^-i) in units of 1e-10 degree.
    localparam longint STEP_RAW [CORDIC_STEPS] = '{
        64'sd450000000000, 64'sd265650511771, 64'sd140362434679,
        64'sd71250163489,  64'sd35763343750,  64'sd17899106082,
        64'sd8951737102,   64'sd4476141709,   64'sd2238105004,
        64'sd1119056771,   64'sd559528919,    64'sd279764526,
        64'sd139882271,    64'sd69941137,     64'sd34970569,
        64'sd17485284,     64'sd8742642,      64'sd4371321,
        64'sd2185661,      64'sd1092830,      64'sd546415,
        64'sd273208,       64'sd136604,       64'sd68302,
        64'sd34151,        64'sd17075,        64'sd8538,
        64'sd4269
    };

    // Rescales one table entry to FRAC_BITS fraction bits, rounded to nearest.
    function automatic t_angle step_angle(input int idx);
        longint scaled;
        scaled = (STEP_RAW[idx] * (longint'(1) <<< FRAC_BITS) + 64'sd5000000000)
                 / 64'sd10000000000;
        return t_angle'(scaled);
    endfunction

endpackage

// ===== design/chxy_front.sv =====
// ----------------------------------------------------------------------------
// chxy_front: input stage of the compass heading pipeline
// Takes magnitudes and signs of the readings and settles the exact cases.
// ----------------------------------------------------------------------------
module chxy_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  chxy_pkg::t_in_word i_word,
    output logic               o_valid,
    output chxy_pkg::t_cordic  o_data
);

    localparam int HEAD_PAD = chxy_pkg::XY_W - chxy_pkg::SAMPLE_BITS - chxy_pkg::GUARD_BITS;

    logic              x_neg;
    logic              y_neg;
    chxy_pkg::t_sample ax;
    chxy_pkg::t_sample ay;
    chxy_pkg::t_cordic n_data;
    logic              r_valid;
    chxy_pkg::t_cordic r_data;

    assign x_neg = i_word.mag_x[chxy_pkg::SAMPLE_BITS-1];
    assign y_neg = i_word.mag_y[chxy_pkg::SAMPLE_BITS-1];

    // The most negative reading has magnitude 2^(SAMPLE_BITS-1), which still
    // fits as an unsigned value of the same width.
    assign ax = x_neg ? chxy_pkg::t_sample'(~i_word.mag_x + 1'b1) : i_word.mag_x;
    assign ay = y_neg ? chxy_pkg::t_sample'(~i_word.mag_y + 1'b1) : i_word.mag_y;

    always_comb begin
        n_data.x      = chxy_pkg::t_xy'({{HEAD_PAD{1'b0}}, ax,
                                         {chxy_pkg::GUARD_BITS{1'b0}}});
        n_data.y      = chxy_pkg::t_xy'({{HEAD_PAD{1'b0}}, ay,
                                         {chxy_pkg::GUARD_BITS{1'b0}}});
        n_data.x_neg  = x_neg;
        n_data.y_neg  = y_neg;
        n_data.no_dir = (ax == '0) && (ay == '0);
        // On an axis or the diagonal the angle is exact and the CORDIC
        // stages just carry it along.
        n_data.fixed  = (ay == '0) || (ax == '0) || (ax == ay);
        if (ay == '0) begin
            n_data.z = '0;
        end else if (ax == '0) begin
            n_data.z = chxy_pkg::RIGHT_Q;
        end else if (ax == ay) begin
            n_data.z = chxy_pkg::DIAG_Q;
        end else begin
            n_data.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/chxy_stage.sv =====
// ----------------------------------------------------------------------------
// chxy_stage: one CORDIC vectoring step
// Rotates toward the X axis by atan(2^-STEP) and accumulates the angle; fixed items pass unchanged.
// ----------------------------------------------------------------------------
module chxy_stage #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  chxy_pkg::t_cordic i_data,
    output logic              o_valid,
    output chxy_pkg::t_cordic o_data
);

    localparam chxy_pkg::t_angle ANGLE = chxy_pkg::step_angle(STEP);

    chxy_pkg::t_xy     cur_x;
    chxy_pkg::t_xy     cur_y;
    chxy_pkg::t_angle  cur_z;
    chxy_pkg::t_xy     dx;
    chxy_pkg::t_xy     dy;
    chxy_pkg::t_cordic n_data;
    logic              r_valid;
    chxy_pkg::t_cordic r_data;

    assign cur_x = i_data.x;
    assign cur_y = i_data.y;
    assign cur_z = i_data.z;

    // Arithmetic shifts round toward minus infinity.
    assign dx = cur_y >>> STEP;
    assign dy = cur_x >>> STEP;

    always_comb begin
        n_data = i_data;
        if (!i_data.fixed) begin
            if (cur_y > 0) begin
                n_data.x = cur_x + dx;
                n_data.y = cur_y - dy;
                n_data.z = cur_z + ANGLE;
            end else begin
                n_data.x = cur_x - dx;
                n_data.y = cur_y + dy;
                n_data.z = cur_z - ANGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/chxy_back.sv =====
// ----------------------------------------------------------------------------
// chxy_back: output stage of the compass heading pipeline
// Clamps the base angle, places it in its quadrant and forms the word.
// ----------------------------------------------------------------------------
module chxy_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  chxy_pkg::t_cordic   i_data,
    output logic                o_valid,
    output chxy_pkg::t_out_word o_word
);

    chxy_pkg::t_angle    z;
    chxy_pkg::t_base     base;
    chxy_pkg::t_head_q   base_ext;
    chxy_pkg::t_head_q   head_q;
    chxy_pkg::t_heading  deg;
    chxy_pkg::t_out_word n_word;
    logic                r_valid;
    chxy_pkg::t_out_word r_word;

    assign z = i_data.z;

    always_comb begin
        if (z < 0) begin
            base = '0;
        end else if (z > chxy_pkg::RIGHT_Q) begin
            base = chxy_pkg::t_base'(chxy_pkg::RIGHT_Q);
        end else begin
            base = chxy_pkg::t_base'(z);
        end
    end

    assign base_ext = chxy_pkg::t_head_q'(base);

    always_comb begin
        case ({i_data.x_neg, i_data.y_neg})
            2'b00:   head_q = chxy_pkg::TURN_Q - base_ext;
            2'b01:   head_q = base_ext;
            2'b10:   head_q = chxy_pkg::HALF_Q + base_ext;
            default: head_q = chxy_pkg::HALF_Q - base_ext;
        endcase
    end

    assign deg = head_q[chxy_pkg::H_W-1:chxy_pkg::FRAC_BITS];

    always_comb begin
        n_word.no_direction = i_data.no_dir;
        // A full turn wraps to north; the undefined case also reads zero.
        if (i_data.no_dir || (deg >= chxy_pkg::TURN_DEG)) begin
            n_word.heading_deg = '0;
        end else begin
            n_word.heading_deg = deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== design/compass_heading_from_xy.sv =====
// Pipeline: a result strobes once its accepted word has passed one input stage,
// 28 CORDIC step stages and one output stage.
// Throughput: one word per cycle; busy stays low and no stage can stall, so the
// receiver must take each result in the cycle it is shown; the block does not check.
// Reset (synchronous, active low) clears the valid bits of all stages, so
// words in flight are dropped and no result strobes until new words arrive.
// ----------------------------------------------------------------------------
// compass_heading_from_xy: compass heading from magnetometer X and Y
// Pipelined CORDIC arctangent giving the clockwise heading in whole degrees.
// ----------------------------------------------------------------------------
module compass_heading_from_xy (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  chxy_pkg::t_in_word  i_word,
    output logic                o_done,
    output chxy_pkg::t_out_word o_word
);

    localparam int PIPE_LAT = chxy_pkg::CORDIC_STEPS + 2;

    logic              accept;
    logic              stg_valid [chxy_pkg::CORDIC_STEPS+1];
    chxy_pkg::t_cordic stg_data  [chxy_pkg::CORDIC_STEPS+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    chxy_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_word  (i_word),
        .o_valid (stg_valid[0]),
        .o_data  (stg_data[0])
    );

    for (genvar g = 0; g < chxy_pkg::CORDIC_STEPS; g++) begin : g_step
        chxy_stage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    chxy_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[chxy_pkg::CORDIC_STEPS]),
        .i_data  (stg_data[chxy_pkg::CORDIC_STEPS]),
        .o_valid (o_done),
        .o_word  (o_word)
    );

    a_no_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_word.no_direction |-> o_word.heading_deg == '0)
        else $error("undefined heading must read zero");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_word.heading_deg < chxy_pkg::TURN_DEG)
        else $error("heading out of range");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##PIPE_LAT o_done)
        else $error("accepted word gave no result at the expected cycle");

    a_zero_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_word.mag_x == '0) && (i_word.mag_y == '0)
        |-> ##PIPE_LAT (o_done && o_word.no_direction))
        else $error("zero pair did not raise the no-direction flag");

endmodule
